### rtl/ljfd_pkg.sv
// shared types for the longest-job-first dispatcher
package ljfd_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned BurstW = 16;
  localparam int unsigned TickW  = 32;
  localparam int unsigned QueueW = 5;

  localparam logic CmdArrival = 1'b0;
  localparam logic CmdTick    = 1'b1;

  typedef struct packed {
    logic [TickW-1:0]  since;
    logic [BurstW-1:0] burst;
    logic [IdW-1:0]    id;
  } q_entry_t;

  typedef struct packed {
    logic     done;
    q_entry_t best;
  } sched_res_t;

  typedef struct packed {
    logic [TickW-1:0]  now_tick;
    logic [QueueW-1:0] queued_jobs;
    logic              busy_res;
    logic [TickW-1:0]  dispatch_wait;
    logic [BurstW-1:0] dispatch_burst;
    logic [IdW-1:0]    dispatch_id;
    logic              dispatch_valid;
    logic              arrival_accepted;
  } result_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SCAN,
    SC_MOVE
  } sched_state_e;

  typedef enum logic [1:0] {
    TP_IDLE,
    TP_WAIT,
    TP_OUT
  } top_state_e;

endpackage

### rtl/ljfd_ram.sv
// generic single-write, single-read ram with registered read data
module ljfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ljfd_sched.sv
// queue store with longest-burst scan and compaction sequencer
module ljfd_sched import ljfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   push_idx_i,
  input  q_entry_t                         push_entry_i,
  input  logic                             start_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] count_i,
  output sched_res_t                       res_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  sched_state_e    state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_addr_q, rd_addr_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  q_entry_t        best_q, best_d;
  logic            done_q, done_d;

  logic            issue;
  logic            mv_we;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  q_entry_t        ram_wdata;
  q_entry_t        ram_rdata;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          state_d = SC_SCAN;
        end
      end
      SC_SCAN: begin
        if (!issue && !rd_vld_q) begin
          state_d = SC_MOVE;
        end
      end
      SC_MOVE: begin
        if (!issue && !rd_vld_q) begin
          state_d = SC_IDLE;
        end
      end
      default: state_d = SC_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    issue      = 1'b0;
    mv_we      = 1'b0;
    cnt_d      = cnt_q;
    rd_cnt_d   = rd_cnt_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    done_d     = 1'b0;
    unique case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          cnt_d    = count_i;
          rd_cnt_d = '0;
        end
      end
      SC_SCAN: begin
        issue = (rd_cnt_q < cnt_q);
        if (issue) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (rd_vld_q && ((rd_addr_q == '0) || (ram_rdata.burst >= best_q.burst))) begin
          best_d     = ram_rdata;
          best_idx_d = rd_addr_q;
        end
        if (!issue && !rd_vld_q) begin
          rd_cnt_d = CntW'(best_idx_q) + 1'b1;
        end
      end
      SC_MOVE: begin
        issue = (rd_cnt_q < cnt_q);
        if (issue) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        mv_we = rd_vld_q;
        if (!issue && !rd_vld_q) begin
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rd_vld_d  = issue;
  assign rd_addr_d = rd_cnt_q[IdxW-1:0];

  assign ram_we    = push_i | mv_we;
  assign ram_waddr = push_i ? push_idx_i : (rd_addr_q - 1'b1);
  assign ram_wdata = push_i ? push_entry_i : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SC_IDLE;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    rd_cnt_q   <= rd_cnt_d;
    rd_addr_q  <= rd_addr_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
  end

  ljfd_ram #(
    .WIDTH ($bits(q_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_d),
    .rdata_o (ram_rdata)
  );

  assign res_o.done = done_q;
  assign res_o.best = best_q;

endmodule

### rtl/longest_job_first_dispatcher_unit.sv
// Non-preemptive longest-job-first dispatcher. An arrival item (tuser 0) queues a job,
// stamped with the current tick, unless the queue of QUEUE_DEPTH entries is full. A tick
// item (tuser 1) retires the running job once its finish tick is reached, then, when no job
// runs, starts the queued job with the largest burst (ties go to the latest arrival) and
// reports its wait, and last advances the tick. Every item gives exactly one result item.
// Items are handled one at a time; the result register lets the next item in while a result
// waits. A tick that dispatches reads the queue memory once per entry to find the longest
// job and again for each entry behind it to close the gap, through the single read port.
module longest_job_first_dispatcher_unit import ljfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // job_id[7:0], job_burst[23:8]
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // arrival_accepted[0], dispatch_valid[1], dispatch_id[9:2], dispatch_burst[25:10],
  // dispatch_wait[57:26], busy_res[58], queued_jobs[63:59], now_tick[95:64]
  output logic [95:0] m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  top_state_e       state_q, state_d;
  logic [CntW-1:0]  count_q;
  logic [TickW-1:0] tick_q;
  logic             run_q;
  logic [TickW-1:0] finish_q;
  result_t          res_q;
  logic             m_valid_q;
  result_t          m_data_q;

  logic              in_acc;
  logic              is_tick;
  logic              full;
  logic              run_next;
  logic              need_dispatch;
  logic              push;
  logic              start;
  logic              load_out;
  q_entry_t          push_entry;
  sched_res_t        sres;
  logic [TickW-1:0]  tick_inc;
  logic [TickW-1:0]  wait_ticks;
  logic [TickW:0]    fin_sum;
  logic [TickW-1:0]  fin_sat;

  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign is_tick       = (s_axis_tuser == CmdTick);
  assign full          = (count_q == CntW'(QUEUE_DEPTH));
  assign run_next      = run_q & (tick_q < finish_q);
  assign need_dispatch = !run_next && (count_q != '0);
  assign tick_inc      = tick_q + 1'b1;
  assign wait_ticks    = tick_q - sres.best.since;
  assign fin_sum       = {1'b0, tick_q} + {{(TickW + 1 - BurstW){1'b0}}, sres.best.burst};
  assign fin_sat       = fin_sum[TickW] ? '1 : fin_sum[TickW-1:0];

  assign push_entry.id    = s_axis_tdata[7:0];
  assign push_entry.burst = s_axis_tdata[23:8];
  assign push_entry.since = tick_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TP_IDLE: begin
        if (in_acc) begin
          state_d = (is_tick && need_dispatch) ? TP_WAIT : TP_OUT;
        end
      end
      TP_WAIT: begin
        if (sres.done) begin
          state_d = TP_OUT;
        end
      end
      TP_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = TP_IDLE;
        end
      end
      default: state_d = TP_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    push          = 1'b0;
    start         = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      TP_IDLE: begin
        s_axis_tready = 1'b1;
        push          = in_acc && !is_tick && !full;
        start         = in_acc && is_tick && need_dispatch;
      end
      TP_WAIT: ;
      TP_OUT: begin
        load_out = !m_valid_q || m_axis_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TP_IDLE;
      count_q   <= '0;
      tick_q    <= '0;
      run_q     <= 1'b0;
      finish_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == TP_IDLE && in_acc && is_tick) begin
        run_q <= run_next;
        if (!need_dispatch) begin
          tick_q <= tick_inc;
        end
      end
      if (state_q == TP_WAIT && sres.done) begin
        run_q    <= 1'b1;
        finish_q <= fin_sat;
        count_q  <= count_q - 1'b1;
        tick_q   <= tick_inc;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // pending result and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == TP_IDLE && in_acc) begin
      res_q.dispatch_valid   <= 1'b0;
      res_q.dispatch_id      <= '0;
      res_q.dispatch_burst   <= '0;
      res_q.dispatch_wait    <= '0;
      res_q.arrival_accepted <= !is_tick && !full;
      res_q.busy_res         <= is_tick ? run_next : run_q;
      res_q.queued_jobs      <= (!is_tick && !full) ? QueueW'(count_q + 1'b1)
                                                    : QueueW'(count_q);
      res_q.now_tick         <= is_tick ? tick_inc : tick_q;
    end
    if (state_q == TP_WAIT && sres.done) begin
      res_q.dispatch_valid <= 1'b1;
      res_q.dispatch_id    <= sres.best.id;
      res_q.dispatch_burst <= sres.best.burst;
      res_q.dispatch_wait  <= wait_ticks;
      res_q.busy_res       <= 1'b1;
      res_q.queued_jobs    <= QueueW'(count_q - 1'b1);
      res_q.now_tick       <= tick_inc;
    end
    if (load_out) begin
      m_data_q <= res_q;
    end
  end

  ljfd_sched #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_idx_i   (count_q[IdxW-1:0]),
    .push_entry_i (push_entry),
    .start_i      (start),
    .count_i      (count_q),
    .res_o        (sres)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
